// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by ddgate_scan and ddgate_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every edge outside reset
`define ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Condition that must hold on every edge outside reset
`define ASSERT_ALW(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`endif

// ----- rtl/ddgate_pkg.sv -----
// ----------------------------------------------------------------------------
// ddgate_pkg
// Types and constants for the drawdown risk-off position gate.
// ----------------------------------------------------------------------------
package ddgate_pkg;

   localparam int RING_DEPTH = 256;
   localparam int PTR_W      = 8;
   localparam int FILL_W     = 9;

   localparam logic [1:0] CAUSE_DRAWDOWN = 2'd0;
   localparam logic [1:0] CAUSE_VOL      = 2'd1;
   localparam logic [1:0] CAUSE_DEFAULT  = 2'd2;
   localparam logic [1:0] CAUSE_RECLAIM  = 2'd3;

   localparam logic [2:0] REG_DRAWDOWN = 3'd0;
   localparam logic [2:0] REG_PEAK_LEN = 3'd1;
   localparam logic [2:0] REG_MA_SEL   = 3'd2;
   localparam logic [2:0] REG_FLAT_MIN = 3'd3;
   localparam logic [2:0] REG_VOL_PCT  = 3'd4;
   localparam logic [2:0] REG_VOL_WIN  = 3'd5;

   // recovery average selection
   localparam logic [1:0] MA_EMA_SHORT  = 2'd0;
   localparam logic [1:0] MA_EMA_MEDIUM = 2'd1;
   localparam logic [1:0] MA_SMA_FIFTY  = 2'd2;
   localparam logic [1:0] MA_SMA_LONG   = 2'd3;

   typedef struct packed {
      logic        bar_is_daily;
      logic [31:0] close_price;
      logic [31:0] vol_measure;
      logic        vol_valid;
      logic [31:0] ema_short;
      logic [31:0] ema_medium;
      logic [31:0] sma_fifty;
      logic [31:0] sma_long;
      logic [3:0]  avg_valid_mask;
      logic [62:0] close_time;
   } req_type;

   typedef struct packed {
      logic        signal_fired;
      logic        go_long;
      logic [1:0]  cause;
      logic        holding;
      logic [62:0] signal_time;
   } rsp_type;

   // clamped configuration seen by the scan and decision logic
   typedef struct packed {
      logic [8:0] dd_tenths;
      logic [8:0] peak_len;
      logic [1:0] ma_sel;
      logic [4:0] flat_min;
      logic [9:0] vol_pct;
      logic [8:0] vol_win;
   } cfg_type;

   // scan start and result between scanner and control
   typedef struct packed {
      logic        start;
      logic [31:0] close_val;
      logic [31:0] vol_val;
      logic        push_close;
      logic        push_vol;
   } scan_cmd_type;

   typedef struct packed {
      logic        done;
      logic        peak_ok;
      logic [31:0] peak;
      logic        vol_warm;
      logic [8:0]  below;
   } scan_res_type;

endpackage

// ----- rtl/ddgate_csr.sv -----
// ----------------------------------------------------------------------------
// ddgate_csr
// Configuration registers with APB-style access and clamping.
// ----------------------------------------------------------------------------
module ddgate_csr import ddgate_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output cfg_type     cfg
);

   logic [8:0] dd_ff, pw_ff, vw_ff;
   logic [1:0] ms_ff;
   logic [4:0] mf_ff;
   logic [9:0] vp_ff;
   logic       wr;
   logic [2:0] idx;

   assign wr  = psel & penable & pwrite;
   assign idx = paddr[4:2];

   // write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dd_ff <= 9'd150; pw_ff <= 9'd90; ms_ff <= 2'd1;
         mf_ff <= 5'd0;   vp_ff <= 10'd0; vw_ff <= 9'd180;
      end else if (wr) begin
         case (idx)
            REG_DRAWDOWN: dd_ff <= pwdata[8:0];
            REG_PEAK_LEN: pw_ff <= pwdata[8:0];
            REG_MA_SEL:   ms_ff <= pwdata[1:0];
            REG_FLAT_MIN: mf_ff <= pwdata[4:0];
            REG_VOL_PCT:  vp_ff <= pwdata[9:0];
            REG_VOL_WIN:  vw_ff <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (idx)
         REG_DRAWDOWN: prdata = {23'd0, dd_ff};
         REG_PEAK_LEN: prdata = {23'd0, pw_ff};
         REG_MA_SEL:   prdata = {30'd0, ms_ff};
         REG_FLAT_MIN: prdata = {27'd0, mf_ff};
         REG_VOL_PCT:  prdata = {22'd0, vp_ff};
         REG_VOL_WIN:  prdata = {23'd0, vw_ff};
         default:      prdata = 32'd0;
      endcase
   end

   // clamp to legal ranges
   always_comb begin
      cfg.dd_tenths = (dd_ff < 9'd50) ? 9'd50 : ((dd_ff > 9'd500) ? 9'd500 : dd_ff);
      cfg.peak_len  = (pw_ff < 9'd30) ? 9'd30 : ((pw_ff > 9'd256) ? 9'd256 : pw_ff);
      cfg.ma_sel    = ms_ff;
      cfg.flat_min  = mf_ff;
      cfg.vol_pct   = (vp_ff > 10'd990) ? 10'd990 : vp_ff;
      cfg.vol_win   = (vw_ff < 9'd90) ? 9'd90 : ((vw_ff > 9'd256) ? 9'd256 : vw_ff);
   end

endmodule

// ----- rtl/ddgate_scan.sv -----
// ----------------------------------------------------------------------------
// ddgate_scan
// Ring memories of prior closes and volatility values; scans the newest
// entries for the trailing peak and the count of smaller values, then
// pushes the current bar.
// ----------------------------------------------------------------------------
module ddgate_scan import ddgate_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  scan_cmd_type cmd,
   output scan_res_type res
);
`include "assert_macros.svh"

   logic [31:0] close_mem [RING_DEPTH];
   logic [31:0] vol_mem   [RING_DEPTH];
   logic [31:0] close_rd_ff, vol_rd_ff;

   logic [PTR_W-1:0]  cptr_ff, vptr_ff;
   logic [FILL_W-1:0] cfill_ff, vfill_ff;
   logic [FILL_W-1:0] cnt_ff;       // reads issued
   logic              busy_ff, rvalid_ff, fin_ff;
   logic [FILL_W-1:0] rcnt_ff;      // data consumed
   logic [31:0]       peak_ff;
   logic [8:0]        below_ff;
   logic [31:0]       cval_ff, vval_ff;
   logic              pc_ff, pv_ff;
   logic              hp_ff, vw_ff;
   logic [FILL_W-1:0] span;
   logic [PTR_W-1:0]  cidx, vidx;

   assign span = (cfg.peak_len > cfg.vol_win) ? cfg.peak_len : cfg.vol_win;
   assign cidx = cptr_ff - 8'd1 - cnt_ff[PTR_W-1:0];
   assign vidx = vptr_ff - 8'd1 - cnt_ff[PTR_W-1:0];

   // memory reads and the push at the end of the scan
   always_ff @(posedge clock) begin
      close_rd_ff <= close_mem[cidx];
      vol_rd_ff   <= vol_mem[vidx];
      if (fin_ff && pc_ff) close_mem[cptr_ff] <= cval_ff;
      if (fin_ff && pv_ff) vol_mem[vptr_ff]   <= vval_ff;
   end

   // scan sequencing and accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; rvalid_ff <= 1'b0; fin_ff <= 1'b0;
         cptr_ff <= '0; vptr_ff <= '0; cfill_ff <= '0; vfill_ff <= '0;
         cnt_ff <= '0; rcnt_ff <= '0;
      end else begin
         fin_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1; cnt_ff <= '0; rcnt_ff <= '0;
            peak_ff <= '0; below_ff <= '0;
            cval_ff <= cmd.close_val; vval_ff <= cmd.vol_val;
            pc_ff <= cmd.push_close; pv_ff <= cmd.push_vol;
            hp_ff <= cfill_ff >= cfg.peak_len;
            vw_ff <= vfill_ff >= cfg.vol_win;
            rvalid_ff <= 1'b0;
         end else if (busy_ff) begin
            rvalid_ff <= cnt_ff < span;
            if (cnt_ff < span) cnt_ff <= cnt_ff + 9'd1;
            if (rvalid_ff) begin
               if (rcnt_ff < cfg.peak_len && close_rd_ff > peak_ff) peak_ff <= close_rd_ff;
               if (rcnt_ff < cfg.vol_win && vol_rd_ff < vval_ff) below_ff <= below_ff + 9'd1;
               rcnt_ff <= rcnt_ff + 9'd1;
            end
            if (!rvalid_ff && cnt_ff == span) begin
               busy_ff <= 1'b0; fin_ff <= 1'b1;
            end
         end
         if (fin_ff && pc_ff) begin
            cptr_ff <= cptr_ff + 8'd1;
            if (cfill_ff < 9'd256) cfill_ff <= cfill_ff + 9'd1;
         end
         if (fin_ff && pv_ff) begin
            vptr_ff <= vptr_ff + 8'd1;
            if (vfill_ff < 9'd256) vfill_ff <= vfill_ff + 9'd1;
         end
      end
   end

   assign res.done      = fin_ff;
   assign res.peak_ok   = hp_ff;
   assign res.peak      = peak_ff;
   assign res.vol_warm  = vw_ff;
   assign res.below     = below_ff;

   `ASSERT_ALW(a_fill_c, clock, reset, cfill_ff <= 9'd256)
   `ASSERT_ALW(a_fill_v, clock, reset, vfill_ff <= 9'd256)
   `ASSERT_IMP(a_start_idle, clock, reset, cmd.start, !busy_ff)
   `ASSERT_IMP(a_fin, clock, reset, fin_ff, !busy_ff)

endmodule

// ----- rtl/ddgate_ctrl.sv -----
// ----------------------------------------------------------------------------
// ddgate_ctrl
// Sequencer and position decision for one request at a time.
// ----------------------------------------------------------------------------
module ddgate_ctrl import ddgate_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   output scan_cmd_type cmd,
   input  scan_res_type res
);
`include "assert_macros.svh"

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_SCAN = 4'b0010, ST_MUL = 4'b0100, ST_OUT = 4'b1000
   } state_type;

   state_type   st_ff;
   req_type     req_ff;
   logic        long_ff, once_ff;
   logic [5:0]  flat_ff;
   logic [41:0] lhs_ff, rhs_ff;
   logic [18:0] bl_ff, thr_ff;
   logic        hp_ff, vw_ff;
   rsp_type     out_ff;
   logic        ov_ff;
   logic [31:0] ma;
   logic        ma_ok, dd, vb, acc;
   logic [5:0]  flat_inc;
   rsp_type     r;

   assign req_ready = (st_ff == ST_IDLE) && !ov_ff;
   assign acc = req_valid && req_ready;

   always_comb begin
      case (cfg.ma_sel)
         MA_EMA_SHORT:  ma = req_ff.ema_short;
         MA_EMA_MEDIUM: ma = req_ff.ema_medium;
         MA_SMA_FIFTY:  ma = req_ff.sma_fifty;
         default:       ma = req_ff.sma_long;
      endcase
   end
   assign ma_ok = req_ff.avg_valid_mask[cfg.ma_sel];
   assign dd = hp_ff && (lhs_ff < rhs_ff);
   assign vb = req_ff.vol_valid && vw_ff && (cfg.vol_pct != 10'd0) && (bl_ff >= thr_ff);
   assign flat_inc = (flat_ff == 6'd63) ? flat_ff : flat_ff + 6'd1;

   // decide
   always_comb begin
      r = '0;
      r.signal_time = req_ff.close_time;
      r.holding = long_ff;
      if (long_ff) begin
         if (dd) begin
            r.signal_fired = 1'b1; r.cause = CAUSE_DRAWDOWN; r.holding = 1'b0;
         end else if (vb) begin
            r.signal_fired = 1'b1; r.cause = CAUSE_VOL; r.holding = 1'b0;
         end
      end else if (hp_ff) begin
         if (!once_ff) begin
            r.signal_fired = 1'b1; r.go_long = 1'b1; r.cause = CAUSE_DEFAULT;
            r.holding = 1'b1;
         end else if (flat_inc >= {1'b0, cfg.flat_min} && !dd && ma_ok
                      && req_ff.close_price > ma) begin
            r.signal_fired = 1'b1; r.go_long = 1'b1; r.cause = CAUSE_RECLAIM;
            r.holding = 1'b1;
         end
      end
   end

   assign cmd.start      = acc && req_data.bar_is_daily;
   assign cmd.close_val  = req_data.close_price;
   assign cmd.vol_val    = req_data.vol_measure;
   assign cmd.push_close = 1'b1;
   assign cmd.push_vol   = req_data.vol_valid;

   // sequence one request: daily bars scan, multiply, decide; others get the held position
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; ov_ff <= 1'b0;
         long_ff <= 1'b0; once_ff <= 1'b0; flat_ff <= '0;
      end else begin
         if (rsp_valid && rsp_ready) ov_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               if (acc) begin
                  req_ff <= req_data;
                  if (req_data.bar_is_daily) begin
                     st_ff <= ST_SCAN;
                  end else begin
                     out_ff <= '{1'b0, 1'b0, 2'd0, long_ff, req_data.close_time};
                     ov_ff <= 1'b1;
                  end
               end
            end
            ST_SCAN: begin
               if (res.done) begin
                  lhs_ff <= 42'(req_ff.close_price) * 42'd1000;
                  rhs_ff <= 42'(res.peak) * 42'(10'd1000 - 10'(cfg.dd_tenths));
                  bl_ff  <= 19'(res.below) * 19'd1000;
                  thr_ff <= 19'(cfg.vol_pct) * 19'(cfg.vol_win);
                  hp_ff <= res.peak_ok; vw_ff <= res.vol_warm;
                  st_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               out_ff <= r;
               long_ff <= r.holding;
               if (long_ff) begin
                  if (r.signal_fired) flat_ff <= '0;
               end else if (hp_ff) begin
                  if (!once_ff) once_ff <= 1'b1;
                  else flat_ff <= r.signal_fired ? 6'd0 : flat_inc;
               end
               st_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!ov_ff || (rsp_valid && rsp_ready)) begin
                  ov_ff <= 1'b1; st_ff <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   `ASSERT_IMP(a_no_acc_busy, clock, reset, st_ff != ST_IDLE, !req_ready)
   `ASSERT_IMP(a_fire_flat, clock, reset,
      st_ff == ST_MUL && long_ff && r.signal_fired, !r.holding)
   `ASSERT_IMP(a_done_scan, clock, reset, res.done, st_ff == ST_SCAN)

endmodule

// ----- rtl/drawdown_riskoff_position_gate_top.sv -----
// ----------------------------------------------------------------------------
// drawdown_riskoff_position_gate_top
// Long/flat gate on daily bars with drawdown and volatility-rank exits.
// ----------------------------------------------------------------------------
//  channel | ports                          | role
//  req     | req_valid/req_ready/req_data   | one bar per request
//  rsp     | rsp_valid/rsp_ready/rsp_data   | one decision per request
//  csr     | psel/penable/pwrite/paddr/...  | six config registers, 4*i
//
// A daily bar is answered after the one-entry-a-cycle scan of the two ring
// memories over max(peak_window, vol_window) entries (windows as clamped),
// then the ST_MUL and ST_OUT states. Other bars respond in the next cycle.
// A new request is taken only once the previous response is accepted.
// Synchronous active-high reset clears control state; ring data is only
// used once fill counts cover windows. A stalled response holds the block.
module drawdown_riskoff_position_gate_top import ddgate_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type      cfg;
   scan_cmd_type cmd;
   scan_res_type res;

   assign pready = 1'b1;

   ddgate_csr u_csr (.clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
                     .prdata, .cfg);
   ddgate_scan u_scan (.clock, .reset, .cfg, .cmd, .res);
   ddgate_ctrl u_ctrl (.clock, .reset, .cfg, .req_valid, .req_ready, .req_data,
                       .rsp_valid, .rsp_ready, .rsp_data, .cmd, .res);

endmodule
